// ===== hw/rtl/bounded_deque_with_value_delete_assert.svh =====
// Assertion macros shared by the deque checker.
// Depends on a clock named clk and a synchronous reset named rst in the using module.
`ifndef BOUNDED_DEQUE_WITH_VALUE_DELETE_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_VALUE_DELETE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BDQ_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bdq: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BDQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bdq: next-cycle check failed");

// The consequent must hold in the cycle after reset is sampled high.
`define BDQ_ASSERT_RESET(label, cons) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("bdq: post-reset check failed");

`endif

// ===== hw/rtl/bdq_pkg.sv =====
// Shared types and constants of the bounded deque.
// Used by the controller, the datapath, the top level and the checker.
package bdq_pkg;

  localparam int DataW     = 32;
  localparam int ModeW     = 4;
  localparam int PrintCntW = 7;

  // Operation codes carried in the mode field.
  localparam logic [ModeW-1:0] MODE_PUSH_FRONT = 4'd0;
  localparam logic [ModeW-1:0] MODE_PUSH_BACK  = 4'd1;
  localparam logic [ModeW-1:0] MODE_POP_FRONT  = 4'd2;
  localparam logic [ModeW-1:0] MODE_POP_BACK   = 4'd3;
  localparam logic [ModeW-1:0] MODE_CLEAR      = 4'd4;
  localparam logic [ModeW-1:0] MODE_DELETE     = 4'd5;
  localparam logic [ModeW-1:0] MODE_PRINT_ALL  = 4'd6;
  localparam logic [ModeW-1:0] MODE_PRINT_FIRST = 4'd7;
  localparam logic [ModeW-1:0] MODE_PRINT_LAST = 4'd8;

  // State update the datapath performs this cycle.
  typedef enum logic [2:0] {
    DP_NONE,
    DP_PUSH_FRONT,
    DP_PUSH_BACK,
    DP_DROP_HEAD,
    DP_DROP_TAIL,
    DP_CLEAR,
    DP_SHIFT,
    DP_SHIFT_END
  } dp_op_t;

  // Which logical position the store is read at.
  typedef enum logic [1:0] {
    RS_ZERO,
    RS_TAIL,
    RS_PTR,
    RS_RUN
  } rd_src_t;

  typedef enum logic [1:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_ONE,
    PTR_INC
  } ptr_op_t;

  typedef struct packed {
    dp_op_t  op;
    logic    load;
    logic    rd_en;
    rd_src_t rd_src;
    logic    rd_to_out;
    ptr_op_t ptr_op;
    logic    push_empty;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic at_most_two;
    logic match;
    logic dpos_cm2;
    logic dpos_cm1;
    logic ptr_lt_count;
    logic ptr_last;
    logic n_zero;
    logic credit;
  } dp_stat_t;

endpackage

// ===== hw/rtl/bdq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/bdq_ctrl.sv =====
// Controller state machine of the bounded deque.
// Depends on bdq_pkg for the command and status structs and the mode codes.
module bdq_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bdq_pkg::ModeW-1:0]    mode,
  input  bdq_pkg::dp_stat_t            stat,
  output bdq_pkg::dp_cmd_t             cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEL_HEAD,
    S_DEL_TAIL,
    S_DEL_SCAN,
    S_DEL_SHIFT,
    S_PRINT
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd.op         = bdq_pkg::DP_NONE;
    cmd.load       = 1'b0;
    cmd.rd_en      = 1'b0;
    cmd.rd_src     = bdq_pkg::RS_PTR;
    cmd.rd_to_out  = 1'b0;
    cmd.ptr_op     = bdq_pkg::PTR_HOLD;
    cmd.push_empty = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          unique case (mode)
            bdq_pkg::MODE_PUSH_FRONT: begin
              if (!stat.full) cmd.op = bdq_pkg::DP_PUSH_FRONT;
            end
            bdq_pkg::MODE_PUSH_BACK: begin
              if (!stat.full) cmd.op = bdq_pkg::DP_PUSH_BACK;
            end
            bdq_pkg::MODE_POP_FRONT: cmd.op = bdq_pkg::DP_DROP_HEAD;
            bdq_pkg::MODE_POP_BACK:  cmd.op = bdq_pkg::DP_DROP_TAIL;
            bdq_pkg::MODE_CLEAR:     cmd.op = bdq_pkg::DP_CLEAR;
            bdq_pkg::MODE_DELETE: begin
              if (!stat.empty) begin
                cmd.rd_en  = 1'b1;
                cmd.rd_src = bdq_pkg::RS_ZERO;
                state_next = S_DEL_HEAD;
              end
            end
            bdq_pkg::MODE_PRINT_ALL, bdq_pkg::MODE_PRINT_FIRST,
            bdq_pkg::MODE_PRINT_LAST: begin
              cmd.ptr_op = bdq_pkg::PTR_ZERO;
              state_next = S_PRINT;
            end
            default: ;
          endcase
        end
      end
      S_DEL_HEAD: begin
        if (stat.match) begin
          cmd.op     = bdq_pkg::DP_DROP_HEAD;
          state_next = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = bdq_pkg::RS_TAIL;
          cmd.ptr_op = bdq_pkg::PTR_ONE;
          state_next = S_DEL_TAIL;
        end
      end
      S_DEL_TAIL: begin
        if (stat.match) begin
          cmd.op     = bdq_pkg::DP_DROP_TAIL;
          state_next = S_IDLE;
        end else if (stat.at_most_two) begin
          state_next = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.ptr_op = bdq_pkg::PTR_INC;
          state_next = S_DEL_SCAN;
        end
      end
      S_DEL_SCAN: begin
        cmd.rd_en = stat.ptr_lt_count;
        if (stat.ptr_lt_count) cmd.ptr_op = bdq_pkg::PTR_INC;
        if (stat.match) begin
          state_next = S_DEL_SHIFT;
        end else if (stat.dpos_cm2) begin
          state_next = S_IDLE;
        end
      end
      S_DEL_SHIFT: begin
        cmd.rd_en = stat.ptr_lt_count;
        if (stat.ptr_lt_count) cmd.ptr_op = bdq_pkg::PTR_INC;
        if (stat.dpos_cm1) begin
          cmd.op     = bdq_pkg::DP_SHIFT_END;
          state_next = S_IDLE;
        end else begin
          cmd.op = bdq_pkg::DP_SHIFT;
        end
      end
      S_PRINT: begin
        if (stat.credit) begin
          if (stat.n_zero) begin
            cmd.push_empty = 1'b1;
            state_next     = S_IDLE;
          end else begin
            cmd.rd_en     = 1'b1;
            cmd.rd_src    = bdq_pkg::RS_RUN;
            cmd.rd_to_out = 1'b1;
            cmd.ptr_op    = bdq_pkg::PTR_INC;
            if (stat.ptr_last) state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/bdq_dp.sv =====
// Datapath of the bounded deque: circular store, head and count registers,
// read pipeline and two-word output queue. Depends on bdq_pkg and bdq_ram.
module bdq_dp #(
  parameter int CAPACITY = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [bdq_pkg::ModeW-1:0]         mode,
  input  logic signed [bdq_pkg::DataW-1:0]  item_value,
  input  logic [bdq_pkg::PrintCntW-1:0]     print_count,
  input  bdq_pkg::dp_cmd_t                  cmd,
  output bdq_pkg::dp_stat_t                 stat,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [bdq_pkg::DataW-1:0]  out_value,
  output logic                              last_of_run,
  output logic                              nothing_printed
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapCount = CW'(CAPACITY);
  localparam logic [IW-1:0] LastSlot = IW'(CAPACITY - 1);

  function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] base,
                                            input logic [CW-1:0] pos);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(pos);
    if (sum >= (CW+1)'(CAPACITY)) sum = sum - (CW+1)'(CAPACITY);
    return sum[IW-1:0];
  endfunction

  logic [IW-1:0]             front_index;
  logic [CW-1:0]             entry_count;
  logic [bdq_pkg::DataW-1:0] key;
  logic [CW-1:0]             run_len;
  logic                      rev;
  logic [CW-1:0]             ptr;
  logic                      dv;
  logic [CW-1:0]             dpos;
  logic                      dto_out;
  logic                      dlast;

  logic [IW-1:0]             front_dec;
  logic [IW-1:0]             front_inc;
  logic [CW-1:0]             rd_pos;
  logic                      we;
  logic [IW-1:0]             waddr;
  logic [bdq_pkg::DataW-1:0] wdata;
  logic [bdq_pkg::DataW-1:0] rdata;
  logic [bdq_pkg::PrintCntW-1:0] count_wide;

  logic [bdq_pkg::DataW-1:0] fifo_value [2];
  logic                      fifo_last  [2];
  logic                      fifo_empty [2];
  logic                      wp;
  logic                      rp;
  logic [1:0]                occ;
  logic                      push;
  logic                      push_rd;
  logic                      pop;
  logic [2:0]                occ_sum;

  assign front_dec  = (front_index == '0) ? LastSlot : front_index - IW'(1);
  assign front_inc  = (front_index == LastSlot) ? '0 : front_index + IW'(1);
  assign count_wide = bdq_pkg::PrintCntW'(entry_count);

  always_comb begin
    unique case (cmd.rd_src)
      bdq_pkg::RS_ZERO: rd_pos = '0;
      bdq_pkg::RS_TAIL: rd_pos = entry_count - CW'(1);
      bdq_pkg::RS_PTR:  rd_pos = ptr;
      bdq_pkg::RS_RUN:  rd_pos = rev ? (entry_count - CW'(1) - ptr) : ptr;
      default:          rd_pos = ptr;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = slot_of(front_index, dpos - CW'(1));
    wdata = rdata;
    unique case (cmd.op)
      bdq_pkg::DP_PUSH_FRONT: begin
        we    = 1'b1;
        waddr = front_dec;
        wdata = item_value;
      end
      bdq_pkg::DP_PUSH_BACK: begin
        we    = 1'b1;
        waddr = slot_of(front_index, entry_count);
        wdata = item_value;
      end
      bdq_pkg::DP_SHIFT, bdq_pkg::DP_SHIFT_END: we = 1'b1;
      default: ;
    endcase
  end

  bdq_ram #(
    .WIDTH(bdq_pkg::DataW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (slot_of(front_index, rd_pos)),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      front_index <= '0;
      entry_count <= '0;
    end else begin
      unique case (cmd.op)
        bdq_pkg::DP_PUSH_FRONT: begin
          front_index <= front_dec;
          entry_count <= entry_count + CW'(1);
        end
        bdq_pkg::DP_PUSH_BACK: entry_count <= entry_count + CW'(1);
        bdq_pkg::DP_DROP_HEAD: begin
          if (entry_count != '0) begin
            front_index <= front_inc;
            entry_count <= entry_count - CW'(1);
          end
        end
        bdq_pkg::DP_DROP_TAIL: begin
          if (entry_count != '0) entry_count <= entry_count - CW'(1);
        end
        bdq_pkg::DP_CLEAR: begin
          front_index <= '0;
          entry_count <= '0;
        end
        bdq_pkg::DP_SHIFT_END: entry_count <= entry_count - CW'(1);
        default: ;
      endcase
    end
  end

  // Operands of the accepted word, held for the multi-cycle operations.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key <= item_value;
      rev <= (mode == bdq_pkg::MODE_PRINT_LAST);
      if (mode == bdq_pkg::MODE_PRINT_ALL || print_count >= count_wide) begin
        run_len <= entry_count;
      end else begin
        run_len <= print_count[CW-1:0];
      end
    end
    unique case (cmd.ptr_op)
      bdq_pkg::PTR_ZERO: ptr <= '0;
      bdq_pkg::PTR_ONE:  ptr <= CW'(1);
      bdq_pkg::PTR_INC:  ptr <= ptr + CW'(1);
      default: ;
    endcase
    dpos  <= rd_pos;
    dlast <= stat.ptr_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv      <= 1'b0;
      dto_out <= 1'b0;
    end else begin
      dv      <= cmd.rd_en;
      dto_out <= cmd.rd_to_out;
    end
  end

  // Two-word output queue; a read is only issued when its word has room.
  assign push_rd = dv && dto_out;
  assign push    = push_rd || cmd.push_empty;
  assign pop     = out_valid && out_ready;
  assign occ_sum = 3'(occ) + 3'(push_rd);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      occ <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      occ <= occ + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_value[wp] <= cmd.push_empty ? '0 : rdata;
      fifo_last[wp]  <= cmd.push_empty || dlast;
      fifo_empty[wp] <= cmd.push_empty;
    end
  end

  assign out_valid       = (occ != '0);
  assign out_value       = fifo_value[rp];
  assign last_of_run     = fifo_last[rp];
  assign nothing_printed = fifo_empty[rp];

  always_comb begin
    stat.full         = (entry_count == CapCount);
    stat.empty        = (entry_count == '0);
    stat.at_most_two  = (entry_count <= CW'(2));
    stat.match        = (rdata == key);
    stat.dpos_cm2     = ((CW+1)'(dpos) + (CW+1)'(2)) == (CW+1)'(entry_count);
    stat.dpos_cm1     = ((CW+1)'(dpos) + (CW+1)'(1)) == (CW+1)'(entry_count);
    stat.ptr_lt_count = (ptr < entry_count);
    stat.ptr_last     = ((CW+1)'(ptr) + (CW+1)'(1)) == (CW+1)'(run_len);
    stat.n_zero       = (run_len == '0);
    stat.credit       = (occ_sum <= (3'(pop) + 3'd1));
  end

endmodule

// ===== hw/rtl/bounded_deque_with_value_delete.sv =====
// Bounded deque of signed 32-bit words. Push, pop and clear words complete in the idle state.
// Delete checks the head, then the tail, then scans the middle entries one by one and,
// on a hit, moves the later ones. A print of n entries streams one word per cycle
// from the single store read port while the output queue has room for it.
// Reset clears head and count; store contents stay undefined, no clearing pass.
//
// The controller (bdq_ctrl) sequences the multi-cycle operations and drives the
// datapath (bdq_dp) through a command struct; the datapath reports back through a
// status struct. The datapath holds the circular store in a generic RAM, the head
// index and entry count, a one-stage read pipeline, and a two-word output queue.
// A new input word is taken only while the controller is idle, but finished print
// words can still be waiting in the output queue at that point: the output side
// never blocks the next simple operation. Delete by value first compares the head,
// then the tail, then scans the middle from the head; on a middle hit every later
// entry is moved one place toward the head, one entry per cycle, overlapping the
// read of the next entry with the write of the current one.
module bounded_deque_with_value_delete #(
  parameter int CAPACITY = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bdq_pkg::ModeW-1:0]         mode,
  input  logic signed [bdq_pkg::DataW-1:0]  item_value,
  input  logic [bdq_pkg::PrintCntW-1:0]     print_count,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [bdq_pkg::DataW-1:0]  out_value,
  output logic                              last_of_run,
  output logic                              nothing_printed
);

  // Command and status between the controller and the datapath.
  bdq_pkg::dp_cmd_t  cmd;
  bdq_pkg::dp_stat_t stat;

  bdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .mode     (mode),
    .stat     (stat),
    .cmd      (cmd)
  );

  bdq_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .mode            (mode),
    .item_value      (item_value),
    .print_count     (print_count),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_value       (out_value),
    .last_of_run     (last_of_run),
    .nothing_printed (nothing_printed)
  );

endmodule

// ===== hw/rtl/bdq_checker.sv =====
// Port-level checker for the bounded deque, attached to the top level by bind.
// Depends on bdq_pkg and bounded_deque_with_value_delete_assert.svh.
`include "bounded_deque_with_value_delete_assert.svh"

module bdq_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [bdq_pkg::ModeW-1:0]         mode,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [bdq_pkg::DataW-1:0]  out_value,
  input logic                              last_of_run,
  input logic                              nothing_printed
);

  // After reset the block is idle with nothing to deliver.
  `BDQ_ASSERT_RESET(a_reset_idle, !out_valid && in_ready)

  // An empty print is always a run of one word with a zero value.
  `BDQ_ASSERT_SAME(a_empty_word, out_valid && nothing_printed, last_of_run && out_value == '0)

  // Simple operations and unused codes finish in the cycle they are taken.
  `BDQ_ASSERT_NEXT(a_simple_op_done, in_valid && in_ready && (mode <= bdq_pkg::MODE_CLEAR || mode > bdq_pkg::MODE_PRINT_LAST), in_ready)

  // A stalled output word holds.
  `BDQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(last_of_run) && $stable(nothing_printed))

endmodule

bind bounded_deque_with_value_delete bdq_checker u_bdq_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .mode            (mode),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_value       (out_value),
  .last_of_run     (last_of_run),
  .nothing_printed (nothing_printed)
);

// ===== verif/deque_checker.sv =====
// Checker for the bounded deque: tracks the held entries, predicts every print word
// and compares the output channel against it. Depends on bdq_pkg only.
module deque_checker #(
  parameter int CAPACITY = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [bdq_pkg::ModeW-1:0]           mode,
  input  logic signed [bdq_pkg::DataW-1:0]    item_value,
  input  logic [bdq_pkg::PrintCntW-1:0]       print_count,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [bdq_pkg::DataW-1:0]    out_value,
  input  logic                                last_of_run,
  input  logic                                nothing_printed,
  output int                                  mismatches,
  output int                                  words_waiting,
  output int                                  words_checked
);

  typedef struct packed {
    logic signed [bdq_pkg::DataW-1:0] value;
    logic                             last;
    logic                             empty;
  } print_word_t;

  // Entries currently held, head first, and the print words still owed.
  logic signed [bdq_pkg::DataW-1:0] held[$];
  print_word_t                      owed_words[$];

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("deque_checker: %s", what);
  endtask

  // Queue up the words of one print run of up to n entries from either end.
  task automatic predict_run(input int unsigned n, input bit from_tail);
    print_word_t w;
    int unsigned take;
    take = (n > held.size()) ? held.size() : n;
    if (take == 0) begin
      w.value = '0;
      w.last  = 1'b1;
      w.empty = 1'b1;
      owed_words.push_back(w);
    end else begin
      for (int unsigned i = 0; i < take; i++) begin
        w.value = from_tail ? held[held.size() - 1 - i] : held[i];
        w.last  = (i + 1 == take);
        w.empty = 1'b0;
        owed_words.push_back(w);
      end
    end
  endtask

  always @(posedge clk) begin : track
    print_word_t want;
    int hit;
    if (rst) begin
      held.delete();
      owed_words.delete();
    end else begin
      if (out_valid && out_ready) begin
        words_checked++;
        if (owed_words.size() == 0) begin
          report_mismatch($sformatf("print word %0d with none owed", out_value));
        end else begin
          want = owed_words.pop_front();
          // An empty print carries a zero value.
          if (out_value !== want.value)
            report_mismatch($sformatf("value %0d, predicted %0d", out_value, want.value));
          if (last_of_run !== want.last)
            report_mismatch($sformatf("last_of_run %b, predicted %b", last_of_run, want.last));
          if (nothing_printed !== want.empty)
            report_mismatch($sformatf("nothing_printed %b, predicted %b",
                                      nothing_printed, want.empty));
        end
      end
      if (in_valid && in_ready) begin
        case (mode)
          bdq_pkg::MODE_PUSH_FRONT: if (held.size() < CAPACITY) held.push_front(item_value);
          bdq_pkg::MODE_PUSH_BACK:  if (held.size() < CAPACITY) held.push_back(item_value);
          bdq_pkg::MODE_POP_FRONT:  if (held.size() != 0) void'(held.pop_front());
          bdq_pkg::MODE_POP_BACK:   if (held.size() != 0) void'(held.pop_back());
          bdq_pkg::MODE_CLEAR:      held.delete();
          bdq_pkg::MODE_DELETE: begin
            if (held.size() != 0) begin
              if (held[0] == item_value) begin
                void'(held.pop_front());
              end else if (held[held.size() - 1] == item_value) begin
                void'(held.pop_back());
              end else begin
                hit = -1;
                for (int p = 1; p < held.size() - 1; p++)
                  if (hit < 0 && held[p] == item_value) hit = p;
                if (hit > 0) held.delete(hit);
              end
            end
          end
          bdq_pkg::MODE_PRINT_ALL:   predict_run(held.size(), 1'b0);
          bdq_pkg::MODE_PRINT_FIRST: predict_run(print_count, 1'b0);
          bdq_pkg::MODE_PRINT_LAST:  predict_run(print_count, 1'b1);
          default: ;
        endcase
      end
    end
    words_waiting = owed_words.size();
  end

endmodule

// ===== verif/tb_top.sv =====
// Top of the bounded deque testbench: clock, reset, operation stimulus and verdict.
// Depends on bdq_pkg, the bounded_deque_with_value_delete block and deque_checker.
module tb_top;

  localparam int CAPACITY     = 64;
  // Operation words in the whole run, directed ones included.
  localparam int ITEM_WORDS   = 370;
  // A fill episode is CAPACITY + 2 pushes followed by three prints.
  localparam int FILL_WORDS   = CAPACITY + 5;
  // The slowest correct run prints 64 words per operation word with every output
  // word stalled for the longest burst, which stays far under this limit.
  localparam int CYCLE_LIMIT  = 2000000;
  // A value delete can run without producing a word, so the tail of the run waits
  // longer than the longest delete once nothing is owed.
  localparam int DRAIN_CYCLES = CAPACITY + 24;
  // Mode codes the block has no operation for.
  localparam logic [bdq_pkg::ModeW-1:0] MODE_SPARE_LO = 4'd9;
  localparam logic [bdq_pkg::ModeW-1:0] MODE_SPARE_HI = 4'd15;
  localparam logic signed [bdq_pkg::DataW-1:0] MOST_NEG = 32'sh8000_0000;
  localparam logic signed [bdq_pkg::DataW-1:0] MOST_POS = 32'sh7fff_ffff;

  // Every input of the block starts at a known value.
  logic                              clk         = 1'b0;
  logic                              rst         = 1'b1;
  logic                              in_valid    = 1'b0;
  logic [bdq_pkg::ModeW-1:0]         mode        = bdq_pkg::MODE_CLEAR;
  logic signed [bdq_pkg::DataW-1:0]  item_value  = '0;
  logic [bdq_pkg::PrintCntW-1:0]     print_count = '0;
  logic                              out_ready   = 1'b0;
  logic                              in_ready;
  logic                              out_valid;
  logic signed [bdq_pkg::DataW-1:0]  out_value;
  logic                              last_of_run;
  logic                              nothing_printed;

  // When calm is set neither side idles any more; it is raised for the last stretch.
  logic        calm          = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int          words_sent    = 0;
  int          directed_words;
  int          cycles        = 0;
  int          mismatches;
  int          words_waiting;
  int          words_checked;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  bounded_deque_with_value_delete #(.CAPACITY(CAPACITY)) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .item_value     (item_value),
    .print_count    (print_count),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_value      (out_value),
    .last_of_run    (last_of_run),
    .nothing_printed(nothing_printed)
  );

  deque_checker #(.CAPACITY(CAPACITY)) watch (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .item_value     (item_value),
    .print_count    (print_count),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_value      (out_value),
    .last_of_run    (last_of_run),
    .nothing_printed(nothing_printed),
    .mismatches     (mismatches),
    .words_waiting  (words_waiting),
    .words_checked  (words_checked)
  );

  // Drives one operation word and returns at the edge where it is accepted. A gap
  // drops valid first and raises it again at a later edge, never in the same step.
  task automatic send_word(input logic [bdq_pkg::ModeW-1:0] m,
                           input logic signed [bdq_pkg::DataW-1:0] v,
                           input logic [bdq_pkg::PrintCntW-1:0] n);
    if (!calm && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= m;
    item_value  <= v;
    print_count <= n;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // Values lean toward a small pool so deletes find their targets often, with the
  // extremes and fully random words mixed in so every bit toggles.
  function automatic logic signed [bdq_pkg::DataW-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return MOST_NEG;
      1:       return MOST_POS;
      2, 3, 4: return bdq_pkg::DataW'($urandom_range(0, 6) - 3);
      default: return $urandom;
    endcase
  endfunction

  // Counts are mostly short; some span the whole store and some the whole field.
  function automatic logic [bdq_pkg::PrintCntW-1:0] pick_count();
    case ($urandom_range(0, 7))
      0:       return bdq_pkg::PrintCntW'($urandom_range(0, 127));
      1:       return bdq_pkg::PrintCntW'($urandom_range(0, CAPACITY));
      default: return bdq_pkg::PrintCntW'($urandom_range(0, 10));
    endcase
  endfunction

  // Some stretches run without idling, others with light or heavy idling.
  function automatic int unsigned pick_idle_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 15;
      default: return 50;
    endcase
  endfunction

  // One word of the general mix: pushes outweigh removals so the store fills up and
  // deletes have middle entries to hit.
  task automatic send_random_word();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 22)      send_word(bdq_pkg::MODE_PUSH_BACK, pick_value(), pick_count());
    else if (roll < 40) send_word(bdq_pkg::MODE_PUSH_FRONT, pick_value(), pick_count());
    else if (roll < 48) send_word(bdq_pkg::MODE_POP_FRONT, pick_value(), pick_count());
    else if (roll < 55) send_word(bdq_pkg::MODE_POP_BACK, pick_value(), pick_count());
    else if (roll < 57) send_word(bdq_pkg::MODE_CLEAR, pick_value(), pick_count());
    else if (roll < 72) send_word(bdq_pkg::MODE_DELETE, pick_value(), pick_count());
    else if (roll < 78) send_word(bdq_pkg::MODE_PRINT_ALL, pick_value(), pick_count());
    else if (roll < 88) send_word(bdq_pkg::MODE_PRINT_FIRST, pick_value(), pick_count());
    else if (roll < 97) send_word(bdq_pkg::MODE_PRINT_LAST, pick_value(), pick_count());
    else send_word(bdq_pkg::ModeW'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI)),
                   pick_value(), pick_count());
  endtask

  // The output side stalls in random bursts; ready is set exactly once in any step.
  initial begin
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 99) < recv_idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int burst;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words: light idling on both sides so gaps land here too.
    send_idle_pct = 20;
    recv_idle_pct = 20;
    // An empty store prints one word flagged as empty, and pops and deletes on it
    // change nothing.
    send_word(bdq_pkg::MODE_PRINT_ALL, 0, 0);
    send_word(bdq_pkg::MODE_POP_FRONT, 0, 0);
    send_word(bdq_pkg::MODE_POP_BACK, 0, 0);
    send_word(bdq_pkg::MODE_DELETE, MOST_POS, 0);
    // Popping the only entry leaves the store empty.
    send_word(bdq_pkg::MODE_PUSH_FRONT, 5, 0);
    send_word(bdq_pkg::MODE_POP_BACK, 0, 0);
    // Build most negative, most positive, 0, -1, 0, 9 with the extremes at the head.
    send_word(bdq_pkg::MODE_PUSH_BACK, MOST_POS, 0);
    send_word(bdq_pkg::MODE_PUSH_FRONT, MOST_NEG, 0);
    send_word(bdq_pkg::MODE_PUSH_BACK, 0, 0);
    send_word(bdq_pkg::MODE_PUSH_BACK, -32'sd1, 0);
    send_word(bdq_pkg::MODE_PUSH_BACK, 0, 0);
    send_word(bdq_pkg::MODE_PUSH_BACK, 9, 0);
    // Head match, then the first of two middle zeros, then a tail match.
    send_word(bdq_pkg::MODE_DELETE, MOST_NEG, 0);
    send_word(bdq_pkg::MODE_DELETE, 0, 0);
    send_word(bdq_pkg::MODE_DELETE, 9, 0);
    // Print everything, a zero count, a short count, and a count past what is held.
    send_word(bdq_pkg::MODE_PRINT_ALL, 0, 0);
    send_word(bdq_pkg::MODE_PRINT_FIRST, 0, 7'd0);
    send_word(bdq_pkg::MODE_PRINT_FIRST, 0, 7'd2);
    send_word(bdq_pkg::MODE_PRINT_LAST, 0, 7'd127);
    // Unused mode codes do nothing at all.
    send_word(MODE_SPARE_LO, MOST_NEG, 7'd64);
    send_word(MODE_SPARE_HI, MOST_POS, 7'd127);
    // After a clear the store prints empty; a delete that misses the only entry
    // leaves it in place.
    send_word(bdq_pkg::MODE_CLEAR, 0, 0);
    send_word(bdq_pkg::MODE_PRINT_FIRST, 0, 7'd3);
    send_word(bdq_pkg::MODE_PUSH_BACK, 1, 0);
    send_word(bdq_pkg::MODE_DELETE, 2, 0);
    send_word(bdq_pkg::MODE_PRINT_ALL, 0, 0);
    directed_words = words_sent;

    // Random part in episodes: mostly the general mix, now and then a fill past
    // capacity so dropped pushes and full-length prints from both ends happen. A
    // fill only starts while it still fits, and the last bursts are trimmed so the
    // run ends on the planned word count.
    while (words_sent < ITEM_WORDS) begin
      send_idle_pct = pick_idle_pct();
      recv_idle_pct = pick_idle_pct();
      if (words_sent + 40 >= ITEM_WORDS) calm = 1'b1;
      if (words_sent + FILL_WORDS + 40 < ITEM_WORDS && $urandom_range(0, 5) == 0) begin
        repeat (CAPACITY + 2)
          send_word($urandom_range(0, 1) ? bdq_pkg::MODE_PUSH_FRONT
                                         : bdq_pkg::MODE_PUSH_BACK,
                    pick_value(), pick_count());
        send_word(bdq_pkg::MODE_PRINT_ALL, pick_value(), pick_count());
        send_word(bdq_pkg::MODE_PRINT_LAST, pick_value(), bdq_pkg::PrintCntW'(CAPACITY));
        send_word(bdq_pkg::MODE_PRINT_FIRST, pick_value(), pick_count());
      end else begin
        burst = $urandom_range(8, 24);
        if (burst > ITEM_WORDS - words_sent) burst = ITEM_WORDS - words_sent;
        repeat (burst) send_random_word();
      end
    end
    in_valid <= 1'b0;

    // Let the checker see the last accepted word, wait until no print word is owed,
    // then give a trailing delete time to finish and any stray word time to show.
    @(posedge clk);
    while (words_waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d operation words (%0d directed), %0d print words checked",
             words_sent, directed_words, words_checked);
    $display("summary: %0d mismatches, %0d print words still owed", mismatches,
             words_waiting);
    if (mismatches == 0 && words_waiting == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== bounded_deque_with_value_delete.f =====
+incdir+hw/rtl
hw/rtl/bdq_pkg.sv
hw/rtl/bdq_ram.sv
hw/rtl/bdq_ctrl.sv
hw/rtl/bdq_dp.sv
hw/rtl/bounded_deque_with_value_delete.sv
hw/rtl/bdq_checker.sv
verif/deque_checker.sv
verif/tb_top.sv
